// ----- design/bap_pkg.sv -----
// ----------------------------------------------------------------------------
// bap_pkg
// Shared widths, register indexes and controller states for the binarize
// average pool block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bap_pkg;

    localparam int CFG_DATA_W   = 11;
    localparam int CFG_INDEX_W  = 2;
    localparam int IMG_W        = 11;
    localparam int WIN_W        = 5;
    localparam int POS_W        = 10;
    localparam int WPOS_W       = 4;
    localparam int HSUM_W       = 5;
    localparam int COLSUM_W     = 9;
    localparam int AREA_W       = 10;
    localparam int MEAN_W       = 17;
    localparam int FRAC_W       = 16;
    localparam int NUMER_W      = COLSUM_W + FRAC_W;
    localparam int PIXEL_W      = 16;
    localparam int S_USER_W     = 1;
    localparam int M_DATA_W     = 40;

    localparam logic [IMG_W-1:0]    IMAGE_HEIGHT_MAX = 11'd1024;
    localparam logic [HSUM_W-1:0]   HSUM_MAX         = 5'd31;
    localparam logic [COLSUM_W:0]   COLSUM_MAX       = 10'd511;
    localparam logic [NUMER_W-1:0]  ONE_Q16          = 25'd65536;

    localparam logic [IMG_W-1:0]    RST_IMAGE_WIDTH   = 11'd64;
    localparam logic [IMG_W-1:0]    RST_IMAGE_HEIGHT  = 11'd64;
    localparam logic [WIN_W-1:0]    RST_WINDOW_HEIGHT = 5'd2;
    localparam logic [WIN_W-1:0]    RST_WINDOW_WIDTH  = 5'd2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT,
        REG_WINDOW_HEIGHT,
        REG_WINDOW_WIDTH
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_RD,
        ST_MERGE,
        ST_MEAN
    } state_t;

endpackage

// ----- design/bap_ram.sv -----
// ----------------------------------------------------------------------------
// bap_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bap_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/bap_div.sv -----
// ----------------------------------------------------------------------------
// bap_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bap_div #(
    parameter int NUM_W = 10,
    parameter int DEN_W = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg,  busy_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [NUM_W-1:0] num_reg,   num_next;
    logic [DEN_W-1:0] rem_reg,   rem_next;
    logic [DEN_W-1:0] den_reg,   den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            num_next  = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            // quotient bits shift in where numerator bits leave
            num_next = {num_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign quot = num_reg;

endmodule

// ----- design/binarize_average_pool.sv -----
// ----------------------------------------------------------------------------
// binarize_average_pool
// Binarizes a raster pixel stream (above zero -> 1) and emits the mean of
// each whole non-overlapping window_height x window_width tile as Q1.16.
// Usage:
//   s_ channel: one pixel per transaction, s_tuser marks start of frame.
//   m_ channel: one transaction per whole tile, m_tlast on the final tile.
//   cfg port: write image and window sizes between images.
// Pixel handling: a pixel that does not close a tile column leaves s_tready
//   high. A pixel that closes a tile column drops s_tready: tile row and
//   column come from two dividers, then one read-modify-write of the
//   column-sum RAM. If it also closes a tile, the mean divider runs and
//   the result waits for a free output register before s_tready returns.
// Reset: counters clear, registers return to 64x64 image, 2x2 tile; the
//   column-sum RAM is not cleared and needs no clearing pass.
// Stall: one finished result waits in the output register while pixels
//   keep flowing; only a pixel with a new result waits for m_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binarize_average_pool #(
    parameter int MAX_IMAGE_WIDTH = 1024,
    parameter int MAX_WINDOW_SIDE = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [bap_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bap_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bap_pkg::PIXEL_W-1:0]      s_tdata,   // [15:0] pixel
    input  logic [bap_pkg::S_USER_W-1:0]     s_tuser,   // [0] start_of_frame
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [16:0] feature_mean, [26:17] feature_row, [36:27] feature_col, zero pad
    output logic [bap_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                             m_tlast    // last_feature
);

    import bap_pkg::*;

    localparam int AW = $clog2(MAX_IMAGE_WIDTH);

    // configuration
    logic [IMG_W-1:0] image_width_reg, image_height_reg;
    logic [WIN_W-1:0] window_height_reg, window_width_reg;
    logic [IMG_W-1:0] w_c, h_c;
    logic [WIN_W-1:0] wh_c, ww_c;

    // position state
    logic [POS_W-1:0]  pixel_x_reg,  pixel_x_next;
    logic [POS_W-1:0]  pixel_y_reg,  pixel_y_next;
    logic [WPOS_W-1:0] x_in_win_reg, x_in_win_next;
    logic [WPOS_W-1:0] y_in_win_reg, y_in_win_next;
    logic [HSUM_W-1:0] hsum_reg,     hsum_next;

    // captured per-item values
    logic [POS_W-1:0]  pos_x_reg,  pos_x_next;
    logic [POS_W-1:0]  pos_y_reg,  pos_y_next;
    logic [WPOS_W-1:0] cap_yw_reg, cap_yw_next;
    logic [HSUM_W-1:0] cap_hs_reg, cap_hs_next;
    logic              cap_wye_reg, cap_wye_next;
    logic              res_last_reg, res_last_next;

    state_t state_reg, state_next;

    // output register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [MEAN_W-1:0] m_mean_reg,   m_mean_next;
    logic [POS_W-1:0]  m_row_reg,    m_row_next;
    logic [POS_W-1:0]  m_col_reg,    m_col_next;
    logic              m_last_reg,   m_last_next;

    // datapath
    logic              accept, sof, one;
    logic [POS_W-1:0]  x0, y0;
    logic [WPOS_W-1:0] xw0, yw0;
    logic [HSUM_W-1:0] hs0, hs1;
    logic              row_end, win_x_end, win_y_end;
    logic              pos_start, pos_busy_c, pos_busy_r;
    logic [POS_W-1:0]  tcol, trow;
    logic              col_in_ram;
    logic              ram_we;
    logic [COLSUM_W-1:0] ram_rdata, col_sum;
    logic [COLSUM_W:0]   sum_wide;
    logic [IMG_W-1:0]  tcol_p1, tcol_p2, trow_p1, trow_p2;
    logic [15:0]       col_lim1, col_lim2, row_lim1, row_lim2;
    logic              col_ok, row_ok, col_last, row_last, emit;
    logic [AREA_W-1:0] area;
    logic [NUMER_W-1:0] mean_num, mean_quot;
    logic              mean_start, mean_busy;
    logic              out_free;

    // ------------------------------------------------------------------
    // configuration registers and clamping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
            window_height_reg <= RST_WINDOW_HEIGHT;
            window_width_reg  <= RST_WINDOW_WIDTH;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                REG_WINDOW_HEIGHT: window_height_reg <= cfg_data[WIN_W-1:0];
                REG_WINDOW_WIDTH:  window_width_reg  <= cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (image_width_reg == '0) begin
            w_c = IMG_W'(1);
        end else if (32'(image_width_reg) > 32'(MAX_IMAGE_WIDTH)) begin
            w_c = IMG_W'(MAX_IMAGE_WIDTH);
        end else begin
            w_c = image_width_reg;
        end
        if (image_height_reg == '0) begin
            h_c = IMG_W'(1);
        end else if (image_height_reg > IMAGE_HEIGHT_MAX) begin
            h_c = IMAGE_HEIGHT_MAX;
        end else begin
            h_c = image_height_reg;
        end
        if (window_height_reg == '0) begin
            wh_c = WIN_W'(1);
        end else if (32'(window_height_reg) > 32'(MAX_WINDOW_SIDE)) begin
            wh_c = WIN_W'(MAX_WINDOW_SIDE);
        end else begin
            wh_c = window_height_reg;
        end
        if (window_width_reg == '0) begin
            ww_c = WIN_W'(1);
        end else if (32'(window_width_reg) > 32'(MAX_WINDOW_SIDE)) begin
            ww_c = WIN_W'(MAX_WINDOW_SIDE);
        end else begin
            ww_c = window_width_reg;
        end
    end

    // ------------------------------------------------------------------
    // pixel intake: position counters advance in the accepting cycle
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign sof      = s_tuser[0];
    assign one      = !s_tdata[PIXEL_W-1] && (s_tdata != '0);

    always_comb begin
        x0  = sof ? '0 : pixel_x_reg;
        y0  = sof ? '0 : pixel_y_reg;
        xw0 = sof ? '0 : x_in_win_reg;
        yw0 = sof ? '0 : y_in_win_reg;
        hs0 = sof ? '0 : hsum_reg;
        hs1 = (one && hs0 != HSUM_MAX) ? hs0 + HSUM_W'(1) : hs0;

        row_end   = ({1'b0, x0} + IMG_W'(1)) >= w_c;
        win_x_end = ({1'b0, xw0} + WIN_W'(1)) >= ww_c;
        win_y_end = ({1'b0, yw0} + WIN_W'(1)) >= wh_c;

        pixel_x_next  = pixel_x_reg;
        pixel_y_next  = pixel_y_reg;
        x_in_win_next = x_in_win_reg;
        y_in_win_next = y_in_win_reg;
        hsum_next     = hsum_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        cap_yw_next   = cap_yw_reg;
        cap_hs_next   = cap_hs_reg;
        cap_wye_next  = cap_wye_reg;

        if (accept) begin
            pos_x_next   = x0;
            pos_y_next   = y0;
            cap_yw_next  = yw0;
            cap_hs_next  = hs1;
            cap_wye_next = win_y_end;
            if (win_x_end) begin
                hsum_next     = '0;
                x_in_win_next = '0;
            end else begin
                hsum_next     = hs1;
                x_in_win_next = xw0 + WPOS_W'(1);
            end
            pixel_y_next  = y0;
            y_in_win_next = yw0;
            if (row_end) begin
                pixel_x_next  = '0;
                x_in_win_next = '0;
                hsum_next     = '0;
                if (({1'b0, y0} + IMG_W'(1)) >= h_c) begin
                    pixel_y_next  = '0;
                    y_in_win_next = '0;
                end else begin
                    pixel_y_next  = y0 + POS_W'(1);
                    y_in_win_next = win_y_end ? '0 : yw0 + WPOS_W'(1);
                end
            end else begin
                pixel_x_next = x0 + POS_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // tile position dividers
    assign pos_start = accept && win_x_end;

    bap_div #(
        .NUM_W (POS_W),
        .DEN_W (WIN_W)
    ) u_div_col (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pos_start),
        .num     (x0),
        .den     (ww_c),
        .busy    (pos_busy_c),
        .quot    (tcol)
    );

    bap_div #(
        .NUM_W (POS_W),
        .DEN_W (WIN_W)
    ) u_div_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pos_start),
        .num     (y0),
        .den     (wh_c),
        .busy    (pos_busy_r),
        .quot    (trow)
    );

    assign col_in_ram = 32'(tcol) < 32'(MAX_IMAGE_WIDTH);

    // ------------------------------------------------------------------
    // column sum line store: read in ST_RD, written back in ST_MERGE
    bap_ram #(
        .WIDTH (COLSUM_W),
        .DEPTH (MAX_IMAGE_WIDTH)
    ) u_colsum_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (AW'(tcol)),
        .wdata (col_sum),
        .rdata (ram_rdata)
    );

    always_comb begin
        sum_wide = (COLSUM_W + 1)'(cap_hs_reg);
        if (cap_yw_reg != '0) begin
            sum_wide = sum_wide + {1'b0, ram_rdata};
        end
        col_sum = (sum_wide > COLSUM_MAX) ? COLSUM_MAX[COLSUM_W-1:0]
                                          : sum_wide[COLSUM_W-1:0];

        // tile index inside the feature map: (idx + 1) * side <= size
        tcol_p1  = {1'b0, tcol} + IMG_W'(1);
        tcol_p2  = {1'b0, tcol} + IMG_W'(2);
        trow_p1  = {1'b0, trow} + IMG_W'(1);
        trow_p2  = {1'b0, trow} + IMG_W'(2);
        col_lim1 = 16'(tcol_p1) * 16'(ww_c);
        col_lim2 = 16'(tcol_p2) * 16'(ww_c);
        row_lim1 = 16'(trow_p1) * 16'(wh_c);
        row_lim2 = 16'(trow_p2) * 16'(wh_c);
        col_ok   = col_lim1 <= 16'(w_c);
        row_ok   = row_lim1 <= 16'(h_c);
        col_last = col_lim2 > 16'(w_c);
        row_last = row_lim2 > 16'(h_c);
        emit     = cap_wye_reg && col_ok && row_ok;

        area     = AREA_W'(wh_c) * AREA_W'(ww_c);
        mean_num = {col_sum, FRAC_W'(0)} + NUMER_W'(area >> 1);
    end

    // ------------------------------------------------------------------
    // mean divider
    bap_div #(
        .NUM_W (NUMER_W),
        .DEN_W (AREA_W)
    ) u_div_mean (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mean_start),
        .num     (mean_num),
        .den     (area),
        .busy    (mean_busy),
        .quot    (mean_quot)
    );

    // ------------------------------------------------------------------
    // controller
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pixel_x_reg  <= '0;
            pixel_y_reg  <= '0;
            x_in_win_reg <= '0;
            y_in_win_reg <= '0;
            hsum_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pixel_x_reg  <= pixel_x_next;
            pixel_y_reg  <= pixel_y_next;
            x_in_win_reg <= x_in_win_next;
            y_in_win_reg <= y_in_win_next;
            hsum_reg     <= hsum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pos_x_reg    <= pos_x_next;
        pos_y_reg    <= pos_y_next;
        cap_yw_reg   <= cap_yw_next;
        cap_hs_reg   <= cap_hs_next;
        cap_wye_reg  <= cap_wye_next;
        res_last_reg <= res_last_next;
        m_mean_reg   <= m_mean_next;
        m_row_reg    <= m_row_next;
        m_col_reg    <= m_col_next;
        m_last_reg   <= m_last_next;
    end

    always_comb begin
        state_next    = state_reg;
        ram_we        = 1'b0;
        mean_start    = 1'b0;
        res_last_next = res_last_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_mean_next   = m_mean_reg;
        m_row_next    = m_row_reg;
        m_col_next    = m_col_reg;
        m_last_next   = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (pos_start) begin
                    state_next = ST_POS;
                end
            end
            ST_POS: begin
                if (!pos_busy_c && !pos_busy_r) begin
                    state_next = col_in_ram ? ST_RD : ST_IDLE;
                end
            end
            ST_RD: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                ram_we = 1'b1;
                if (emit) begin
                    mean_start    = 1'b1;
                    res_last_next = col_last && row_last;
                    state_next    = ST_MEAN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MEAN: begin
                if (!mean_busy && out_free) begin
                    m_tvalid_next = 1'b1;
                    m_mean_next   = (mean_quot > ONE_Q16) ? ONE_Q16[MEAN_W-1:0]
                                                          : mean_quot[MEAN_W-1:0];
                    m_row_next    = trow;
                    m_col_next    = tcol;
                    m_last_next   = res_last_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({m_col_reg, m_row_reg, m_mean_reg});
    assign m_tlast  = m_last_reg;

    // ------------------------------------------------------------------
    // assertions
    a_mean_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_mean_reg <= ONE_Q16[MEAN_W-1:0]))
        else $error("feature mean above 1.0");

    a_tcol_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |->
            ((16'(tcol) * 16'(ww_c)) <= 16'(pos_x_reg)) &&
            (col_lim1 > 16'(pos_x_reg)))
        else $error("tile column quotient wrong");

    a_trow_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |->
            ((16'(trow) * 16'(wh_c)) <= 16'(pos_y_reg)) &&
            (row_lim1 > 16'(pos_y_reg)))
        else $error("tile row quotient wrong");

    a_mean_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mean_start |-> !mean_busy && !(m_tvalid_reg && !m_tready && state_reg == ST_MEAN))
        else $error("mean divider restarted while busy");

    a_ram_wr_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> $past(state_reg) == ST_RD)
        else $error("column sum written without a read the cycle before");

endmodule
